FILE: hdl/isoar_pkg.sv
package isoar_pkg;

	// Default widths of the sample path
	localparam int RAW_WIDTH_DEF     = 16;
	localparam int OUT_FRAC_BITS_DEF = 16;

	// Fixed formats; the wide word holds the negated sum of two minimum values
	localparam int SCALE_W         = 24;
	localparam int SCALE_FRAC_BITS = 24;
	localparam int DATA_W          = 32;
	localparam int WIDE_W          = DATA_W + 2;
	localparam int ORIENT_W        = 5;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int COS_W           = 17;
	localparam int ROT_FRAC_BITS   = 16;

	localparam logic [COS_W-1:0] COS45_Q16 = 17'd46341;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z   = 3'd4;

	// Yaw rotation orientation codes
	localparam logic [ORIENT_W-1:0] ORIENT_YAW45  = 5'd24;
	localparam logic [ORIENT_W-1:0] ORIENT_YAW135 = 5'd25;
	localparam logic [ORIENT_W-1:0] ORIENT_YAW225 = 5'd26;
	localparam logic [ORIENT_W-1:0] ORIENT_YAW315 = 5'd27;

	// Axis selector: bits 1..0 source axis, bit 2 negate
	localparam logic [2:0] SRC_X  = 3'd0;
	localparam logic [2:0] SRC_Y  = 3'd1;
	localparam logic [2:0] SRC_Z  = 3'd2;
	localparam logic [2:0] SRC_NX = 3'd4;
	localparam logic [2:0] SRC_NY = 3'd5;
	localparam logic [2:0] SRC_NZ = 3'd6;

	// Load enables of the pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// Signed permutation for each orientation code, {x, y, z} selectors
	function automatic logic [8:0] perm_map(input logic [ORIENT_W-1:0] code);
		logic [8:0] m;
		case (code)
			5'd0:    m = {SRC_X,  SRC_Y,  SRC_Z};
			5'd1:    m = {SRC_Y,  SRC_NX, SRC_Z};
			5'd2:    m = {SRC_NX, SRC_NY, SRC_Z};
			5'd3:    m = {SRC_NY, SRC_X,  SRC_Z};
			5'd4:    m = {SRC_X,  SRC_NY, SRC_NZ};
			5'd5:    m = {SRC_Y,  SRC_X,  SRC_NZ};
			5'd6:    m = {SRC_NX, SRC_Y,  SRC_NZ};
			5'd7:    m = {SRC_NY, SRC_NX, SRC_NZ};
			5'd8:    m = {SRC_Z,  SRC_NY, SRC_X};
			5'd9:    m = {SRC_Y,  SRC_Z,  SRC_X};
			5'd10:   m = {SRC_NZ, SRC_Y,  SRC_X};
			5'd11:   m = {SRC_NY, SRC_NZ, SRC_X};
			5'd12:   m = {SRC_Z,  SRC_Y,  SRC_NX};
			5'd13:   m = {SRC_Y,  SRC_NZ, SRC_NX};
			5'd14:   m = {SRC_NZ, SRC_NY, SRC_NX};
			5'd15:   m = {SRC_NY, SRC_Z,  SRC_NX};
			5'd16:   m = {SRC_Z,  SRC_X,  SRC_Y};
			5'd17:   m = {SRC_NX, SRC_Z,  SRC_Y};
			5'd18:   m = {SRC_NZ, SRC_NX, SRC_Y};
			5'd19:   m = {SRC_X,  SRC_NZ, SRC_Y};
			5'd20:   m = {SRC_Z,  SRC_NX, SRC_NY};
			5'd21:   m = {SRC_NX, SRC_NZ, SRC_NY};
			5'd22:   m = {SRC_NZ, SRC_X,  SRC_NY};
			5'd23:   m = {SRC_X,  SRC_Z,  SRC_NY};
			default: m = {SRC_X,  SRC_Y,  SRC_Z};
		endcase
		return m;
	endfunction

endpackage

FILE: hdl/isoar_ifs.sv
// Raw sample channel
interface isoar_raw_if #(
	parameter int RAW_WIDTH = isoar_pkg::RAW_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [RAW_WIDTH-1:0] raw_x;
	logic signed [RAW_WIDTH-1:0] raw_y;
	logic signed [RAW_WIDTH-1:0] raw_z;

	modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
	modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

// Board frame result channel
interface isoar_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [isoar_pkg::DATA_W-1:0] out_x;
	logic signed [isoar_pkg::DATA_W-1:0] out_y;
	logic signed [isoar_pkg::DATA_W-1:0] out_z;
	logic                                saturated;

	modport source (output valid, output out_x, output out_y, output out_z,
		output saturated, input ready);
	modport sink   (input valid, input out_x, input out_y, input out_z,
		input saturated, output ready);
endinterface

FILE: hdl/isoar_front.sv
// One axis: scale multiply (stage 1), shift, offset removal and clipping (stage 2)
module isoar_front #(
	parameter int RAW_WIDTH     = isoar_pkg::RAW_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = isoar_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  isoar_pkg::stage_en_t                en,
	input  logic signed [RAW_WIDTH-1:0]         raw,
	input  logic [isoar_pkg::SCALE_W-1:0]       scale,
	input  logic signed [isoar_pkg::DATA_W-1:0] offset,
	output logic signed [isoar_pkg::DATA_W-1:0] val_s2,
	output logic                                sat_s2
);
	localparam int DW = isoar_pkg::DATA_W;
	localparam int PW = RAW_WIDTH + isoar_pkg::SCALE_W + 1;
	localparam int SH = isoar_pkg::SCALE_FRAC_BITS - OUT_FRAC_BITS;
	localparam logic signed [PW-1:0] P_MAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [PW-1:0] P_MIN = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] shd;
	logic signed [DW-1:0] sc;
	logic                 sc_sat;
	logic signed [DW:0]   diff;
	logic signed [DW-1:0] val;
	logic                 diff_sat;

	// Multiply raw reading by the unsigned scale
	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= $signed(raw) * $signed({1'b0, scale});
		end
	end

	// Floor shift to the output format, clip to 32 bits
	always_comb begin
		shd    = prod_s1 >>> SH;
		sc_sat = 1'b0;
		if (shd > P_MAX) begin
			sc     = {1'b0, {(DW-1){1'b1}}};
			sc_sat = 1'b1;
		end else if (shd < P_MIN) begin
			sc     = {1'b1, {(DW-1){1'b0}}};
			sc_sat = 1'b1;
		end else begin
			sc = shd[DW-1:0];
		end
	end

	// Remove the bias, clip again
	always_comb begin
		diff     = $signed({sc[DW-1], sc}) - $signed({offset[DW-1], offset});
		diff_sat = diff[DW] != diff[DW-1];
		if (diff_sat) begin
			val = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			val = diff[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			val_s2 <= val;
			sat_s2 <= sc_sat | diff_sat;
		end
	end

endmodule

FILE: hdl/isoar_remap.sv
// Stage 3: signed permutation with clipped negation, or yaw rotation sums
module isoar_remap (
	input  logic                                  clk,
	input  isoar_pkg::stage_en_t                  en,
	input  logic [isoar_pkg::ORIENT_W-1:0]        code,
	input  logic signed [isoar_pkg::DATA_W-1:0]   vx,
	input  logic signed [isoar_pkg::DATA_W-1:0]   vy,
	input  logic signed [isoar_pkg::DATA_W-1:0]   vz,
	input  logic                                  flag_in,
	output logic signed [isoar_pkg::WIDE_W-1:0]   a_s3 [3],
	output logic                                  rot_s3,
	output logic                                  flag_s3
);
	localparam int DW = isoar_pkg::DATA_W;
	localparam int WW = isoar_pkg::WIDE_W;
	localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};

	logic signed [DW-1:0] v [3];
	logic [8:0]           pm;
	logic [2:0]           sel [3];
	logic signed [DW-1:0] src [3];
	logic signed [WW-1:0] a [3];
	logic                 neg_sat [3];
	logic signed [WW-1:0] xw;
	logic signed [WW-1:0] yw;
	logic signed [WW-1:0] sum_xy;
	logic signed [WW-1:0] dif_yx;
	logic                 rot;

	assign v[0] = vx;
	assign v[1] = vy;
	assign v[2] = vz;
	assign pm     = isoar_pkg::perm_map(code);
	assign sel[0] = pm[8:6];
	assign sel[1] = pm[5:3];
	assign sel[2] = pm[2:0];
	assign xw     = WW'(vx);
	assign yw     = WW'(vy);
	assign sum_xy = xw + yw;
	assign dif_yx = yw - xw;

	// Pick the source axis and negate where asked, clipping the minimum
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (sel[i][1:0])
				2'd1:    src[i] = v[1];
				2'd2:    src[i] = v[2];
				default: src[i] = v[0];
			endcase
			neg_sat[i] = sel[i][2] && (src[i] == D_MIN);
		end
	end

	// Form the remapped vector or the two rotation sums
	always_comb begin
		rot = 1'b1;
		a[2] = WW'(vz);
		case (code)
			isoar_pkg::ORIENT_YAW45: begin
				a[0] = sum_xy;
				a[1] = dif_yx;
			end
			isoar_pkg::ORIENT_YAW135: begin
				a[0] = dif_yx;
				a[1] = -sum_xy;
			end
			isoar_pkg::ORIENT_YAW225: begin
				a[0] = -sum_xy;
				a[1] = -dif_yx;
			end
			isoar_pkg::ORIENT_YAW315: begin
				a[0] = -dif_yx;
				a[1] = sum_xy;
			end
			default: begin
				rot = 1'b0;
				for (int i = 0; i < 3; i++) begin
					if (neg_sat[i]) begin
						a[i] = WW'(D_MAX);
					end else if (sel[i][2]) begin
						a[i] = -WW'(src[i]);
					end else begin
						a[i] = WW'(src[i]);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			a_s3    <= a;
			rot_s3  <= rot;
			flag_s3 <= flag_in | (!rot && (neg_sat[0] | neg_sat[1] | neg_sat[2]));
		end
	end

endmodule

FILE: hdl/isoar_back.sv
// One axis: cos45 multiply (stage 4), round half up, shift and clip (stage 5)
module isoar_back (
	input  logic                                clk,
	input  isoar_pkg::stage_en_t                en,
	input  logic signed [isoar_pkg::WIDE_W-1:0] a_s3,
	input  logic                                rot_s3,
	output logic signed [isoar_pkg::DATA_W-1:0] res_s5,
	output logic                                sat_s5
);
	localparam int DW = isoar_pkg::DATA_W;
	localparam int WW = isoar_pkg::WIDE_W;
	localparam int FB = isoar_pkg::ROT_FRAC_BITS;
	localparam int MW = WW + isoar_pkg::COS_W + 1;
	localparam logic signed [MW-1:0] HALF  = MW'(1) <<< (FB - 1);
	localparam logic signed [MW-1:0] M_MAX = {{(MW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [MW-1:0] M_MIN = {{(MW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	logic signed [MW-1:0] m_s4;
	logic signed [MW-1:0] rnd;
	logic signed [DW-1:0] res;
	logic                 sat;

	// Scale rotation sums by cos45; lift plain values to the same format
	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (rot_s3) begin
				m_s4 <= a_s3 * $signed({1'b0, isoar_pkg::COS45_Q16});
			end else begin
				m_s4 <= {{(MW-WW-FB){a_s3[WW-1]}}, a_s3, {FB{1'b0}}};
			end
		end
	end

	// Round half up, drop the fraction, clip to 32 bits
	always_comb begin
		rnd = (m_s4 + HALF) >>> FB;
		sat = 1'b0;
		if (rnd > M_MAX) begin
			res = {1'b0, {(DW-1){1'b1}}};
			sat = 1'b1;
		end else if (rnd < M_MIN) begin
			res = {1'b1, {(DW-1){1'b0}}};
			sat = 1'b1;
		end else begin
			res = rnd[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			res_s5 <= res;
			sat_s5 <= sat;
		end
	end

endmodule

FILE: hdl/imu_scale_offset_axis_remap.sv
// Channel   Dir  Beat contents                          Handshake
// sample    in   raw_x, raw_y, raw_z (signed raw)       valid / ready
// result    out  out_x, out_y, out_z (Q16.16), saturated valid / ready
// cfg       in   cfg_idx, cfg_data                      cfg_we, no wait
//
// One beat is taken per cycle unless result stalls a full pipeline; each sample passes stages 1 to 5 in order.
// Stage 1 multiplies by scale, stage 2 removes the offset, stage 3 remaps,
// stage 4 multiplies by cos45 and stage 5 rounds into the output register.
// Reset clears the stage valid bits and the configuration registers.
// A stall on result holds only the stages that are full; bubbles close up,
// so sample stays ready while any stage is empty.
module imu_scale_offset_axis_remap #(
	parameter int RAW_WIDTH     = isoar_pkg::RAW_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = isoar_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	isoar_raw_if.sink                            sample,
	isoar_res_if.source                          result,
	input  logic                                 cfg_we,
	input  logic [isoar_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [isoar_pkg::CFG_DATA_W-1:0]     cfg_data
);
	localparam int DW = isoar_pkg::DATA_W;
	localparam int WW = isoar_pkg::WIDE_W;

	logic [isoar_pkg::ORIENT_W-1:0] axis_order_q;
	logic [isoar_pkg::SCALE_W-1:0]  scale_q;
	logic signed [DW-1:0]           offset_x_q;
	logic signed [DW-1:0]           offset_y_q;
	logic signed [DW-1:0]           offset_z_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	isoar_pkg::stage_en_t en;

	logic signed [DW-1:0] v_s2 [3];
	logic                 sat_s2 [3];
	logic signed [WW-1:0] a_s3 [3];
	logic                 rot_s3;
	logic                 flag_s3;
	logic                 flag_s4;
	logic                 flag_s5;
	logic signed [DW-1:0] res_s5 [3];
	logic                 sat_s5 [3];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_order_q <= '0;
			scale_q      <= '0;
			offset_x_q   <= '0;
			offset_y_q   <= '0;
			offset_z_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				isoar_pkg::REG_AXIS_ORDER: axis_order_q <= cfg_data[isoar_pkg::ORIENT_W-1:0];
				isoar_pkg::REG_SCALE:      scale_q      <= cfg_data[isoar_pkg::SCALE_W-1:0];
				isoar_pkg::REG_OFFSET_X:   offset_x_q   <= cfg_data[DW-1:0];
				isoar_pkg::REG_OFFSET_Y:   offset_y_q   <= cfg_data[DW-1:0];
				isoar_pkg::REG_OFFSET_Z:   offset_z_q   <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its successor moves on
	assign adv_s5 = !vld_s5 || result.ready;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign en     = '{s1: adv_s1, s2: adv_s2, s3: adv_s3, s4: adv_s4, s5: adv_s5};

	assign sample.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= sample.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
		end
	end

	// Scale and offset, one lane per axis
	isoar_front #(.RAW_WIDTH(RAW_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_front_x (
		.clk(clk), .en(en), .raw(sample.raw_x), .scale(scale_q), .offset(offset_x_q),
		.val_s2(v_s2[0]), .sat_s2(sat_s2[0]));
	isoar_front #(.RAW_WIDTH(RAW_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_front_y (
		.clk(clk), .en(en), .raw(sample.raw_y), .scale(scale_q), .offset(offset_y_q),
		.val_s2(v_s2[1]), .sat_s2(sat_s2[1]));
	isoar_front #(.RAW_WIDTH(RAW_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_front_z (
		.clk(clk), .en(en), .raw(sample.raw_z), .scale(scale_q), .offset(offset_z_q),
		.val_s2(v_s2[2]), .sat_s2(sat_s2[2]));

	// Mounting orientation
	isoar_remap u_remap (
		.clk(clk), .en(en), .code(axis_order_q),
		.vx(v_s2[0]), .vy(v_s2[1]), .vz(v_s2[2]),
		.flag_in(sat_s2[0] | sat_s2[1] | sat_s2[2]),
		.a_s3(a_s3), .rot_s3(rot_s3), .flag_s3(flag_s3));

	// Rotation multiply and rounding, one lane per axis
	isoar_back u_back_x (
		.clk(clk), .en(en), .a_s3(a_s3[0]), .rot_s3(rot_s3),
		.res_s5(res_s5[0]), .sat_s5(sat_s5[0]));
	isoar_back u_back_y (
		.clk(clk), .en(en), .a_s3(a_s3[1]), .rot_s3(rot_s3),
		.res_s5(res_s5[1]), .sat_s5(sat_s5[1]));
	isoar_back u_back_z (
		.clk(clk), .en(en), .a_s3(a_s3[2]), .rot_s3(1'b0),
		.res_s5(res_s5[2]), .sat_s5(sat_s5[2]));

	// Carry the clipping flag alongside the data
	always_ff @(posedge clk) begin
		if (en.s4) flag_s4 <= flag_s3;
		if (en.s5) flag_s5 <= flag_s4;
	end

	assign result.valid     = vld_s5;
	assign result.out_x     = res_s5[0];
	assign result.out_y     = res_s5[1];
	assign result.out_z     = res_s5[2];
	assign result.saturated = flag_s5 | sat_s5[0] | sat_s5[1] | sat_s5[2];

	// A full pipeline with a stalled result must refuse new samples
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && !result.ready) |-> !sample.ready)
		else $error("sample accepted into a full stalled pipeline");

	// A stalled stage three keeps its beat and flag
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !adv_s4) |=> (vld_s3 && $stable(flag_s3) && $stable(rot_s3)))
		else $error("stage three lost its beat under stall");

	// Clipping seen before stage five reaches the result
	a_flag_out: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && flag_s4 && adv_s5) |=> (result.valid && result.saturated))
		else $error("clipping flag dropped on the way out");

endmodule
